>>> src/lmcs_pkg.sv
// lmcs_pkg: shared types, constants and codes of the led dot matrix column scan
// no dependencies
`default_nettype none

package lmcs_pkg;

  // defaults of the top level parameters
  localparam int NUM_GLYPHS_DEF       = 128;
  localparam int TICKS_PER_COLUMN_DEF = 5;
  localparam int NUM_CHARS_DEF        = 4;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam int GLYPH_COLS = 5;
  localparam int ROW_W      = 7;
  localparam int MAX_CHARS  = 8;
  localparam int NUM_REGS   = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [ROW_W-1:0] CHAR_RESET = 7'd32;

  // configuration register indexes
  localparam logic [1:0] REG_CHAR_FIRST  = 2'd0;
  localparam logic [1:0] REG_CHAR_SECOND = 2'd1;
  localparam logic [1:0] REG_CHAR_THIRD  = 2'd2;
  localparam logic [1:0] REG_CHAR_FOURTH = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [6:0]       glyph_code;
    logic [2:0]       glyph_column;
    logic [ROW_W-1:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [GLYPH_COLS-1:0] column_select;
    logic                  shift_pulse;
    logic                  serial_data;
    logic                  display_enable;
    logic                  last;
  } out_item_t;

  typedef logic [MAX_CHARS-1:0][ROW_W-1:0] char_arr_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_START,
    CMD_SINGLE
  } cmd_kind_t;

  // one queued command from the front to the back
  typedef struct packed {
    cmd_kind_t             kind;
    logic [GLYPH_COLS-1:0] sel;
    logic                  shift_en;
    logic                  enable;
    logic [2:0]            column;
    logic [6:0]            wr_code;
    logic [2:0]            wr_col;
    logic [ROW_W-1:0]      wr_bits;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHIFT,
    BK_FINAL
  } back_state_t;

endpackage

`default_nettype wire

>>> src/lmcs_ram.sv
// lmcs_ram: generic ram with separate write and read ports, one write and one registered read a cycle
// no dependencies
`default_nettype none

module lmcs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/lmcs_front.sv
// lmcs_front: accepts input items, keeps the scan timing, emits commands
// depends on lmcs_pkg
`default_nettype none

module lmcs_front #(
  parameter int NUM_GLYPHS       = lmcs_pkg::NUM_GLYPHS_DEF,
  parameter int TICKS_PER_COLUMN = lmcs_pkg::TICKS_PER_COLUMN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lmcs_pkg::in_item_t in_data,
  output logic                    q_push,
  output lmcs_pkg::cmd_t          q_data,
  input  wire logic               q_full
);
  import lmcs_pkg::*;

  localparam int PHW = $clog2(TICKS_PER_COLUMN);

  logic [PHW-1:0]        phase_r, phase_nxt;
  logic [2:0]            col_r, col_nxt;
  logic                  enable_r, enable_nxt;
  logic [GLYPH_COLS-1:0] sel_r, sel_nxt;
  logic                  accept;
  logic                  wr_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign wr_ok    = (int'(in_data.glyph_code) < NUM_GLYPHS)
                 && (in_data.glyph_column < 3'(GLYPH_COLS));

  always_comb begin
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    enable_nxt = enable_r;
    sel_nxt    = sel_r;
    q_push     = 1'b0;
    q_data     = '0;
    q_data.wr_code = in_data.glyph_code;
    q_data.wr_col  = in_data.glyph_column;
    q_data.wr_bits = in_data.glyph_bits;
    q_data.shift_en = enable_r;
    if (accept) begin
      if (in_data.operation == OP_WRITE) begin
        q_push      = wr_ok;
        q_data.kind = CMD_WRITE;
      end else begin
        q_push = 1'b1;
        if (phase_r == '0) begin
          q_data.kind = CMD_START;
          sel_nxt     = GLYPH_COLS'(1) << col_r;
          enable_nxt  = 1'b1;
        end else begin
          q_data.kind = CMD_SINGLE;
        end
        if (phase_r == PHW'(TICKS_PER_COLUMN - 1)) begin
          phase_nxt  = '0;
          enable_nxt = 1'b0;
          col_nxt    = (col_r == 3'(GLYPH_COLS - 1)) ? 3'd0 : col_r + 3'd1;
        end else begin
          phase_nxt = phase_r + PHW'(1);
        end
        q_data.sel    = sel_nxt;
        q_data.enable = enable_nxt;
        q_data.column = col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      col_r    <= '0;
      enable_r <= 1'b0;
      sel_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      enable_r <= enable_nxt;
      sel_r    <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/lmcs_queue.sv
// lmcs_queue: short command fifo between front and back
// depends on lmcs_pkg
`default_nettype none

module lmcs_queue #(
  parameter int DEPTH = lmcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lmcs_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output lmcs_pkg::cmd_t      pop_data
);
  import lmcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lmcs_back.sv
// lmcs_back: runs queued commands, owns the font ram and the output register
// depends on lmcs_pkg and lmcs_ram
`default_nettype none

module lmcs_back #(
  parameter int NUM_GLYPHS = lmcs_pkg::NUM_GLYPHS_DEF,
  parameter int NUM_CHARS  = lmcs_pkg::NUM_CHARS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lmcs_pkg::char_arr_t chars,
  input  wire logic                q_valid,
  input  wire lmcs_pkg::cmd_t      q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lmcs_pkg::out_item_t      out_data
);
  import lmcs_pkg::*;

  localparam int DEPTH = NUM_GLYPHS * GLYPH_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [2:0]       b_r, b_nxt;
  logic             blank_r, blank_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_free;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] word;
  logic [6:0]       code;

  lmcs_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_font (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (q_data.wr_bits),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // last character goes out first
  assign code      = chars[3'(NUM_CHARS - 1) - 3'(d_r)];
  assign ram_waddr = AW'(q_data.wr_code) * AW'(GLYPH_COLS) + AW'(q_data.wr_col);
  assign ram_raddr = AW'(code) * AW'(GLYPH_COLS) + AW'(cmd_r.column);
  assign word      = blank_r ? '0 : ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    d_nxt         = d_r;
    b_nxt         = b_r;
    blank_nxt     = blank_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_data.kind)
            CMD_WRITE: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
            end
            CMD_SINGLE: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt       = '{column_select: q_data.sel, shift_pulse: 1'b0,
                                  serial_data: 1'b0, display_enable: q_data.enable,
                                  last: 1'b1};
              end
            end
            CMD_START: begin
              q_pop     = 1'b1;
              cmd_nxt   = q_data;
              d_nxt     = '0;
              state_nxt = BK_READ;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        ram_re    = 1'b1;
        blank_nxt = !(int'(code) < NUM_GLYPHS);
        b_nxt     = 3'(ROW_W - 1);
        state_nxt = BK_SHIFT;
      end
      BK_SHIFT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{column_select: cmd_r.sel, shift_pulse: 1'b1,
                            serial_data: word[b_r], display_enable: cmd_r.shift_en,
                            last: 1'b0};
          if (b_r == '0) begin
            if (d_r == DW'(NUM_CHARS - 1)) begin
              state_nxt = BK_FINAL;
            end else begin
              d_nxt     = d_r + DW'(1);
              state_nxt = BK_READ;
            end
          end else begin
            b_nxt = b_r - 3'd1;
          end
        end
      end
      BK_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{column_select: cmd_r.sel, shift_pulse: 1'b0,
                            serial_data: 1'b0, display_enable: cmd_r.enable,
                            last: 1'b1};
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    d_r     <= d_nxt;
    b_r     <= b_nxt;
    blank_r <= blank_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTH
  a_shift_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.shift_pulse |-> $onehot(out_r.column_select))
    else $error("shift result without a single driven column");
  a_shift_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.shift_pulse |-> !out_r.last)
    else $error("shift result marked last");
  a_data_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.shift_pulse |-> !out_r.serial_data && out_r.last)
    else $error("non-shift result carries data or is not last");
  a_read_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_READ |=> state_r == BK_SHIFT)
    else $error("font read not followed by shifting");
`endif

endmodule

`default_nettype wire

>>> src/led_dot_matrix_column_scan.sv
// led_dot_matrix_column_scan: top level, config registers and front/queue/back
// depends on lmcs_pkg, lmcs_front, lmcs_queue, lmcs_back
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_data (lmcs_pkg::in_item_t)
//  out_    | output    | out_valid/out_ready| out_data (lmcs_pkg::out_item_t)
//  apb     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// a font write or a mid-period tick is done in the back from the idle state; a column
// start tick runs one font ram read and then seven shifted output bits for each
// character, followed by one final output item
// the front takes a new item every cycle while the command queue has room
// output stalls hold the back; the front keeps going until the queue fills
// synchronous active-low reset; the font ram is not cleared, no sweep after reset
`default_nettype none

module led_dot_matrix_column_scan #(
  parameter int NUM_GLYPHS       = lmcs_pkg::NUM_GLYPHS_DEF,
  parameter int TICKS_PER_COLUMN = lmcs_pkg::TICKS_PER_COLUMN_DEF,
  parameter int NUM_CHARS        = lmcs_pkg::NUM_CHARS_DEF,
  parameter int QUEUE_DEPTH      = lmcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lmcs_pkg::in_item_t           in_data,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lmcs_pkg::out_item_t               out_data,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lmcs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lmcs_pkg::PDATA_W-1:0] pwdata,
  output logic      [lmcs_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import lmcs_pkg::*;

  logic [NUM_REGS-1:0][ROW_W-1:0] char_r;
  logic [1:0]                     reg_idx;
  logic                           reg_wr;
  char_arr_t                      chars;

  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t q_push_data, q_pop_data;

  // register file: one glyph code per character position
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(PDATA_W - ROW_W){1'b0}}, char_r[reg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r[REG_CHAR_FIRST]  <= CHAR_RESET;
      char_r[REG_CHAR_SECOND] <= CHAR_RESET;
      char_r[REG_CHAR_THIRD]  <= CHAR_RESET;
      char_r[REG_CHAR_FOURTH] <= CHAR_RESET;
    end else if (reg_wr) begin
      char_r[reg_idx] <= pwdata[ROW_W-1:0];
    end
  end

  // positions beyond the registered four always show the reset code
  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      chars[i] = (i < NUM_REGS) ? char_r[i[1:0]] : CHAR_RESET;
    end
  end

  // front: scan timing and item classification
  lmcs_front #(
    .NUM_GLYPHS       (NUM_GLYPHS),
    .TICKS_PER_COLUMN (TICKS_PER_COLUMN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_push_data),
    .q_full   (q_full)
  );

  // command queue decouples the two sides
  lmcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  // back: font ram, shift sequencer and output register
  lmcs_back #(
    .NUM_GLYPHS (NUM_GLYPHS),
    .NUM_CHARS  (NUM_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chars     (chars),
    .q_valid   (q_not_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
